>>> design/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; imported by every module of the block.
package pps_pkg;

   localparam int MAX_JOBS = 16;
   localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   localparam int ARR_W       = 12;
   localparam int BURST_W     = 12;
   localparam int PRIO_W      = 8;
   localparam int JOB_INDEX_W = 4;
   localparam int TIME_W      = 17;
   localparam int SUM_W       = 21;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STEP,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // store the request's job
      logic scan_start;  // restart the candidate scan
      logic scan;        // examine one stored job
      logic step;        // close the time unit, serve the winner
      logic finish;      // form turnaround and waiting of the winner
      logic emit;        // load the response register
      logic clear;       // end of set, return to empty
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;   // scan sits on the last stored job
      logic found;       // a ready job was seen in this scan
      logic job_done;    // winner has one unit left
      logic set_done;    // next completion finishes the set
      logic out_busy;    // response register still holds a response
   } status_type;

endpackage

>>> design/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: sequencer plus datapath.
// Depends on pps_pkg, pps_ctrl and pps_datapath.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | arrival, burst, priority, last mark
//   rsp_    | out       | rsp_valid/rsp_ready | index, end time, turnaround, waiting, totals
//
// Loading takes one request per cycle; a request beyond MAX_JOBS jobs is dropped.
// The request with the last mark starts the simulation. Each simulated time unit
// scans the n stored jobs one per cycle and then closes with a step; each completion
// adds a finish and an emit state. req_ready is low until the final response is loaded.
// Reset is synchronous and clears the set; job stores hold garbage until loaded.
// A response waiting in the output register does not stop the scan; only a further
// completion stalls until rsp_ready takes the pending one.
module preemptive_priority_scheduler
   import pps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ARR_W-1:0]       req_arrival_time,
   input  logic [BURST_W-1:0]     req_burst_length,
   input  logic [PRIO_W-1:0]      req_priority_level,
   input  logic                   req_last_job,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [JOB_INDEX_W-1:0] rsp_job_index,
   output logic [TIME_W-1:0]      rsp_end_time,
   output logic [TIME_W-1:0]      rsp_turnaround,
   output logic [TIME_W-1:0]      rsp_waiting,
   output logic [SUM_W-1:0]       rsp_total_waiting,
   output logic [SUM_W-1:0]       rsp_total_turnaround,
   output logic                   rsp_last_result
);

   cmd_type    cmd;
   status_type status;

   // sequencer: idle/load, scan, step, finish, emit
   pps_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_job (req_last_job),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd)
   );

   // stores, scan winner, counters, sums and response register
   pps_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_arrival_time     (req_arrival_time),
      .req_burst_length     (req_burst_length),
      .req_priority_level   (req_priority_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_job_index        (rsp_job_index),
      .rsp_end_time         (rsp_end_time),
      .rsp_turnaround       (rsp_turnaround),
      .rsp_waiting          (rsp_waiting),
      .rsp_total_waiting    (rsp_total_waiting),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_last_result      (rsp_last_result)
   );

endmodule

>>> design/pps_ctrl.sv
// Scheduler sequencer: loading, per-time-unit scan, completion steps.
// Depends on pps_pkg.
module pps_ctrl
   import pps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_job,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_last_job) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.found && status.job_done) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FINISH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = status.set_done ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load       = req_valid;
            cmd.scan_start = req_valid && req_last_job;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_STEP: begin
            cmd.step       = 1'b1;
            cmd.scan_start = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit  = !status.out_busy;
            cmd.clear = !status.out_busy && status.set_done;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> design/pps_datapath.sv
// Job stores, candidate scan registers, time/count/sum registers and the
// response register. Depends on pps_pkg; driven by pps_ctrl commands.
module pps_datapath
   import pps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [ARR_W-1:0]       req_arrival_time,
   input  logic [BURST_W-1:0]     req_burst_length,
   input  logic [PRIO_W-1:0]      req_priority_level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [JOB_INDEX_W-1:0] rsp_job_index,
   output logic [TIME_W-1:0]      rsp_end_time,
   output logic [TIME_W-1:0]      rsp_turnaround,
   output logic [TIME_W-1:0]      rsp_waiting,
   output logic [SUM_W-1:0]       rsp_total_waiting,
   output logic [SUM_W-1:0]       rsp_total_turnaround,
   output logic                   rsp_last_result
);

   // job stores
   logic [ARR_W-1:0]   arrival_ff [MAX_JOBS];
   logic [BURST_W-1:0] burst_ff   [MAX_JOBS];
   logic [PRIO_W-1:0]  prio_ff    [MAX_JOBS];
   logic [BURST_W-1:0] remain_ff  [MAX_JOBS];

   // control registers
   logic [CNT_W-1:0]  job_count_ff, job_count_in;
   logic [CNT_W-1:0]  done_count_ff, done_count_in;
   logic [TIME_W-1:0] sim_time_ff, sim_time_in;
   logic [SUM_W-1:0]  sum_wait_ff, sum_wait_in;
   logic [SUM_W-1:0]  sum_tat_ff, sum_tat_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // best candidate of the current scan
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0]  best_prio_ff, best_prio_in;
   logic [ARR_W-1:0]   best_arr_ff, best_arr_in;
   logic [BURST_W-1:0] best_burst_ff, best_burst_in;
   logic [BURST_W-1:0] best_rem_ff, best_rem_in;

   // completion figures
   logic [TIME_W-1:0] tat_ff, tat_in;
   logic [TIME_W-1:0] wt_ff, wt_in;

   // response register
   logic [JOB_INDEX_W-1:0] out_idx_ff, out_idx_in;
   logic [TIME_W-1:0]      out_fin_ff, out_fin_in;
   logic [TIME_W-1:0]      out_tat_ff, out_tat_in;
   logic [TIME_W-1:0]      out_wt_ff, out_wt_in;
   logic [SUM_W-1:0]       out_twt_ff, out_twt_in;
   logic [SUM_W-1:0]       out_ttat_ff, out_ttat_in;
   logic                   out_last_ff, out_last_in;

   logic               has_room;
   logic [BURST_W-1:0] load_burst;
   logic               eligible;
   logic [TIME_W-1:0]  tat_calc;
   logic [SUM_W-1:0]   sum_wait_next;
   logic [SUM_W-1:0]   sum_tat_next;
   logic               set_done;

   assign has_room   = job_count_ff < CNT_W'(MAX_JOBS);
   assign load_burst = (req_burst_length == '0) ? BURST_W'(1) : req_burst_length;

   assign eligible = (TIME_W'(arrival_ff[scan_idx_ff]) <= sim_time_ff)
                  && (remain_ff[scan_idx_ff] != '0)
                  && (!found_ff || (prio_ff[scan_idx_ff] < best_prio_ff));

   assign tat_calc      = sim_time_ff - TIME_W'(best_arr_ff);
   assign sum_wait_next = sum_wait_ff + SUM_W'(wt_ff);
   assign sum_tat_next  = sum_tat_ff + SUM_W'(tat_ff);
   assign set_done      = (done_count_ff + CNT_W'(1)) == job_count_ff;

   assign status.scan_last = (CNT_W'(scan_idx_ff) + CNT_W'(1)) == job_count_ff;
   assign status.found     = found_ff;
   assign status.job_done  = best_rem_ff == BURST_W'(1);
   assign status.set_done  = set_done;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   // stores: written on load, remaining work decremented on a served unit
   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         arrival_ff[job_count_ff[IDX_W-1:0]] <= req_arrival_time;
         burst_ff[job_count_ff[IDX_W-1:0]]   <= load_burst;
         prio_ff[job_count_ff[IDX_W-1:0]]    <= req_priority_level;
         remain_ff[job_count_ff[IDX_W-1:0]]  <= load_burst;
      end else if (cmd.step && found_ff) begin
         remain_ff[best_idx_ff] <= best_rem_ff - BURST_W'(1);
      end
   end

   always_comb begin
      job_count_in  = job_count_ff;
      done_count_in = done_count_ff;
      sim_time_in   = sim_time_ff;
      sum_wait_in   = sum_wait_ff;
      sum_tat_in    = sum_tat_ff;
      scan_idx_in   = scan_idx_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      best_arr_in   = best_arr_ff;
      best_burst_in = best_burst_ff;
      best_rem_in   = best_rem_ff;
      tat_in        = tat_ff;
      wt_in         = wt_ff;
      out_idx_in    = out_idx_ff;
      out_fin_in    = out_fin_ff;
      out_tat_in    = out_tat_ff;
      out_wt_in     = out_wt_ff;
      out_twt_in    = out_twt_ff;
      out_ttat_in   = out_ttat_ff;
      out_last_in   = out_last_ff;

      if (cmd.load && has_room) begin
         job_count_in = job_count_ff + CNT_W'(1);
      end
      if (cmd.scan) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
         if (eligible) begin
            found_in      = 1'b1;
            best_idx_in   = scan_idx_ff;
            best_prio_in  = prio_ff[scan_idx_ff];
            best_arr_in   = arrival_ff[scan_idx_ff];
            best_burst_in = burst_ff[scan_idx_ff];
            best_rem_in   = remain_ff[scan_idx_ff];
         end
      end
      if (cmd.step) begin
         sim_time_in = sim_time_ff + TIME_W'(1);
      end
      if (cmd.scan_start) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
      end
      if (cmd.finish) begin
         tat_in = tat_calc;
         wt_in  = tat_calc - TIME_W'(best_burst_ff);
      end
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         done_count_in = done_count_ff + CNT_W'(1);
         sum_wait_in   = sum_wait_next;
         sum_tat_in    = sum_tat_next;
         out_idx_in    = JOB_INDEX_W'(best_idx_ff);
         out_fin_in    = sim_time_ff;
         out_tat_in    = tat_ff;
         out_wt_in     = wt_ff;
         out_twt_in    = set_done ? sum_wait_next : '0;
         out_ttat_in   = set_done ? sum_tat_next : '0;
         out_last_in   = set_done;
      end
      if (cmd.clear) begin
         job_count_in  = '0;
         done_count_in = '0;
         sim_time_in   = '0;
         sum_wait_in   = '0;
         sum_tat_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff  <= '0;
         done_count_ff <= '0;
         sim_time_ff   <= '0;
         sum_wait_ff   <= '0;
         sum_tat_ff    <= '0;
         scan_idx_ff   <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         job_count_ff  <= job_count_in;
         done_count_ff <= done_count_in;
         sim_time_ff   <= sim_time_in;
         sum_wait_ff   <= sum_wait_in;
         sum_tat_ff    <= sum_tat_in;
         scan_idx_ff   <= scan_idx_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      best_rem_ff   <= best_rem_in;
      tat_ff        <= tat_in;
      wt_ff         <= wt_in;
      out_idx_ff    <= out_idx_in;
      out_fin_ff    <= out_fin_in;
      out_tat_ff    <= out_tat_in;
      out_wt_ff     <= out_wt_in;
      out_twt_ff    <= out_twt_in;
      out_ttat_ff   <= out_ttat_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_job_index        = out_idx_ff;
   assign rsp_end_time         = out_fin_ff;
   assign rsp_turnaround       = out_tat_ff;
   assign rsp_waiting          = out_wt_ff;
   assign rsp_total_waiting    = out_twt_ff;
   assign rsp_total_turnaround = out_ttat_ff;
   assign rsp_last_result      = out_last_ff;

endmodule
